FILE: rtl/core/jpeg_header_marker_parser_macros.svh
// Assertion macros shared by the checker.
`ifndef JPEG_HEADER_MARKER_PARSER_MACROS_SVH
`define JPEG_HEADER_MARKER_PARSER_MACROS_SVH

// clocked implication with reset disable
`define JHMP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication with reset disable
`define JHMP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/jhmp_pkg.sv
package jhmp_pkg;

    localparam int MaxSymbols = 162;
    localparam int TableIds   = 4;
    localparam int QueueDepth = 2;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_QUANT = 3'd1,
        K_HOFF  = 3'd2,
        K_HSYM  = 3'd3,
        K_FRAME = 3'd4,
        K_COMP  = 3'd5,
        K_RST   = 3'd6
    } t_kind;

    localparam logic [4:0] ST_OK        = 5'd0;
    localparam logic [4:0] ST_NO_SOI    = 5'd1;
    localparam logic [4:0] ST_EXP_MK    = 5'd2;
    localparam logic [4:0] ST_DQT_ID    = 5'd3;
    localparam logic [4:0] ST_DHT_ID    = 5'd4;
    localparam logic [4:0] ST_SYMS      = 5'd5;
    localparam logic [4:0] ST_DHT_LEN   = 5'd6;
    localparam logic [4:0] ST_DUP_SOF   = 5'd7;
    localparam logic [4:0] ST_PREC      = 5'd8;
    localparam logic [4:0] ST_ZERO_DIM  = 5'd9;
    localparam logic [4:0] ST_NCOMP     = 5'd10;
    localparam logic [4:0] ST_YIQ       = 5'd11;
    localparam logic [4:0] ST_BAD_CID   = 5'd12;
    localparam logic [4:0] ST_DUP_COMP  = 5'd13;
    localparam logic [4:0] ST_COMP_QT   = 5'd14;
    localparam logic [4:0] ST_SOF_LEN   = 5'd15;
    localparam logic [4:0] ST_TRUNC     = 5'd16;

    // marker codes
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_DQT    = 8'hDB;
    localparam logic [7:0] MK_DRI    = 8'hDD;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_SOF0   = 8'hC0;

    typedef struct packed {
        logic [2:0]  rec_kind;
        logic        table_class;
        logic [1:0]  table_id;
        logic [7:0]  entry_index;
        logic [15:0] value;
        logic [15:0] value2;
        logic        done_res;
        logic [4:0]  status;
        logic        dqt_warn;
        logic        dri_warn;
    } t_result;

    // zigzag position to natural index
    function automatic logic [5:0] zz_rom(input logic [5:0] k);
        logic [5:0] r;
        case (k)
            6'd0: r = 6'd0;   6'd1: r = 6'd1;   6'd2: r = 6'd8;   6'd3: r = 6'd16;
            6'd4: r = 6'd9;   6'd5: r = 6'd2;   6'd6: r = 6'd3;   6'd7: r = 6'd10;
            6'd8: r = 6'd17;  6'd9: r = 6'd24;  6'd10: r = 6'd32; 6'd11: r = 6'd25;
            6'd12: r = 6'd18; 6'd13: r = 6'd11; 6'd14: r = 6'd4;  6'd15: r = 6'd5;
            6'd16: r = 6'd12; 6'd17: r = 6'd19; 6'd18: r = 6'd26; 6'd19: r = 6'd33;
            6'd20: r = 6'd40; 6'd21: r = 6'd48; 6'd22: r = 6'd41; 6'd23: r = 6'd34;
            6'd24: r = 6'd27; 6'd25: r = 6'd20; 6'd26: r = 6'd13; 6'd27: r = 6'd6;
            6'd28: r = 6'd7;  6'd29: r = 6'd14; 6'd30: r = 6'd21; 6'd31: r = 6'd28;
            6'd32: r = 6'd35; 6'd33: r = 6'd42; 6'd34: r = 6'd49; 6'd35: r = 6'd56;
            6'd36: r = 6'd57; 6'd37: r = 6'd50; 6'd38: r = 6'd43; 6'd39: r = 6'd36;
            6'd40: r = 6'd29; 6'd41: r = 6'd22; 6'd42: r = 6'd15; 6'd43: r = 6'd23;
            6'd44: r = 6'd30; 6'd45: r = 6'd37; 6'd46: r = 6'd44; 6'd47: r = 6'd51;
            6'd48: r = 6'd58; 6'd49: r = 6'd59; 6'd50: r = 6'd52; 6'd51: r = 6'd45;
            6'd52: r = 6'd38; 6'd53: r = 6'd31; 6'd54: r = 6'd39; 6'd55: r = 6'd46;
            6'd56: r = 6'd53; 6'd57: r = 6'd60; 6'd58: r = 6'd61; 6'd59: r = 6'd54;
            6'd60: r = 6'd47; 6'd61: r = 6'd55; 6'd62: r = 6'd62; default: r = 6'd63;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/jhmp_parse.sv
// Front part: byte-level segment walker, one byte per cycle while the result queue is not full.
module jhmp_parse import jhmp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_res_valid,
    output t_result     o_res,
    input  logic        i_q_full
);

    typedef enum logic [4:0] {
        PH_SOI0, PH_SOI1, PH_MK0, PH_MK1,
        PH_APP_LH, PH_APP_LL, PH_APP_SKIP,
        PH_DQT_LH, PH_DQT_LL, PH_DQT_INFO, PH_DQT_ENT, PH_DQT_LO,
        PH_DHT_LH, PH_DHT_LL, PH_DHT_INFO, PH_DHT_CNT, PH_DHT_SYM,
        PH_SOF_LH, PH_SOF_LL, PH_SOF_PREC, PH_SOF_HH, PH_SOF_HL, PH_SOF_WH,
        PH_SOF_WL, PH_SOF_NC, PH_SOF_CID, PH_SOF_SAMP, PH_SOF_QT,
        PH_DRI_LH, PH_DRI_LL, PH_DRI_IH, PH_DRI_IL
    } t_phase;

    t_phase             r_phase, n_phase;
    logic signed [17:0] r_rem, n_rem;
    logic [7:0]         r_cnt, n_cnt;
    logic [2:0]         r_tsel, n_tsel;
    logic               r_wide, n_wide;
    logic [7:0]         r_hi, n_hi;
    logic [11:0]        r_sum, n_sum;
    logic [15:0]        r_flen, n_flen;
    logic [15:0]        r_height, n_height;
    logic [1:0]         r_ncomp, n_ncomp;
    logic               r_zb, n_zb;
    logic [2:0]         r_used, n_used;
    logic               r_stop, n_stop;
    logic [1:0]         r_warn, n_warn;

    logic               fire;
    logic               have;
    logic [4:0]         err;
    t_result            rec;
    logic [15:0]        word;
    logic [7:0]         cid;
    logic [11:0]        sum_nx;
    logic signed [17:0] rem_t;

    assign o_stall = i_q_full;
    assign fire    = i_valid && !i_q_full;
    assign word    = {r_hi, i_data_byte};

    always_comb begin
        n_phase = r_phase; n_rem = r_rem; n_cnt = r_cnt; n_tsel = r_tsel;
        n_wide = r_wide; n_hi = r_hi; n_sum = r_sum; n_flen = r_flen;
        n_height = r_height; n_ncomp = r_ncomp; n_zb = r_zb; n_used = r_used;
        n_stop = r_stop; n_warn = r_warn;
        err = ST_OK; have = 1'b0; rec = '0;
        cid = i_data_byte;
        sum_nx = r_sum + 12'(i_data_byte);
        rem_t = r_rem;
        case (r_phase)
            PH_SOI0: if (i_data_byte == MK_PREFIX) n_phase = PH_SOI1; else err = ST_NO_SOI;
            PH_SOI1: if (i_data_byte == MK_SOI) n_phase = PH_MK0; else err = ST_NO_SOI;
            PH_MK0:  if (i_data_byte == MK_PREFIX) n_phase = PH_MK1; else err = ST_EXP_MK;
            PH_MK1: begin
                if (i_data_byte[7:4] == 4'hE) n_phase = PH_APP_LH;
                else if (i_data_byte == MK_DQT) n_phase = PH_DQT_LH;
                else if (i_data_byte == MK_DRI) n_phase = PH_DRI_LH;
                else if (i_data_byte == MK_DHT) n_phase = PH_DHT_LH;
                else if (i_data_byte == MK_SOF0) begin
                    if (r_ncomp != 2'd0) err = ST_DUP_SOF; else n_phase = PH_SOF_LH;
                end else n_phase = PH_MK0;
            end
            PH_APP_LH, PH_DQT_LH, PH_DHT_LH, PH_SOF_LH, PH_SOF_HH, PH_SOF_WH,
            PH_DRI_LH, PH_DRI_IH, PH_SOF_SAMP: begin
                n_hi = i_data_byte;
                n_phase = t_phase'(r_phase + 5'd1);
            end
            PH_APP_LL: begin
                n_rem = (word > 16'd2) ? 18'(word - 16'd2) : '0;
                n_phase = (word > 16'd2) ? PH_APP_SKIP : PH_MK0;
            end
            PH_APP_SKIP: begin
                n_rem = r_rem - 18'sd1;
                if (r_rem <= 18'sd1) n_phase = PH_MK0;
            end
            PH_DQT_LL: begin
                n_rem = $signed({2'b00, word}) - 18'sd2;
                if (n_rem > 0) n_phase = PH_DQT_INFO;
                else begin
                    if (n_rem != 0) n_warn[0] = 1'b1;
                    n_phase = PH_MK0;
                end
            end
            PH_DQT_INFO: begin
                rem_t = r_rem - 18'sd1;
                n_rem = rem_t;
                if (i_data_byte[3:0] >= 4'(TableIds)) err = ST_DQT_ID;
                else begin
                    n_tsel = {1'b0, i_data_byte[1:0]};
                    n_wide = i_data_byte[7:4] != 4'd0;
                    n_rem = rem_t - ((i_data_byte[7:4] != 4'd0) ? 18'sd128 : 18'sd64);
                    n_cnt = '0;
                    n_phase = PH_DQT_ENT;
                end
            end
            PH_DQT_ENT, PH_DQT_LO: begin
                if (r_phase == PH_DQT_ENT && r_wide) begin
                    n_hi = i_data_byte;
                    n_phase = PH_DQT_LO;
                end else begin
                    have = 1'b1;
                    rec.rec_kind = K_QUANT;
                    rec.table_id = r_tsel[1:0];
                    rec.entry_index = {2'b00, zz_rom(r_cnt[5:0])};
                    rec.value = (r_phase == PH_DQT_LO) ? word : {8'h00, i_data_byte};
                    n_cnt = r_cnt + 8'd1;
                    if (r_cnt >= 8'd63) begin
                        if (r_rem > 0) n_phase = PH_DQT_INFO;
                        else begin
                            if (r_rem != 0) n_warn[0] = 1'b1;
                            n_phase = PH_MK0;
                        end
                    end else n_phase = PH_DQT_ENT;
                end
            end
            PH_DHT_LL: begin
                n_rem = $signed({2'b00, word}) - 18'sd2;
                if (n_rem > 0) n_phase = PH_DHT_INFO;
                else if (n_rem != 0) err = ST_DHT_LEN;
                else n_phase = PH_MK0;
            end
            PH_DHT_INFO: begin
                if (i_data_byte[3:0] >= 4'(TableIds)) err = ST_DHT_ID;
                else begin
                    n_tsel = {i_data_byte[7:4] != 4'd0, i_data_byte[1:0]};
                    n_sum = '0;
                    n_cnt = '0;
                    n_phase = PH_DHT_CNT;
                end
            end
            PH_DHT_CNT: begin
                n_sum = sum_nx;
                n_cnt = r_cnt + 8'd1;
                rec.rec_kind = K_HOFF;
                rec.table_class = r_tsel[2];
                rec.table_id = r_tsel[1:0];
                rec.entry_index = r_cnt + 8'd1;
                rec.value = {4'h0, sum_nx};
                if (r_cnt >= 8'd15) begin
                    rem_t = r_rem - 18'sd17 - $signed({6'd0, sum_nx});
                    n_rem = rem_t;
                    if (sum_nx > 12'(MaxSymbols)) err = ST_SYMS;
                    else begin
                        have = 1'b1;
                        if (sum_nx == 12'd0) begin
                            if (rem_t > 0) n_phase = PH_DHT_INFO;
                            else if (rem_t != 0) err = ST_DHT_LEN;
                            else n_phase = PH_MK0;
                        end else begin
                            n_cnt = '0;
                            n_phase = PH_DHT_SYM;
                        end
                    end
                end else have = 1'b1;
            end
            PH_DHT_SYM: begin
                have = 1'b1;
                rec.rec_kind = K_HSYM;
                rec.table_class = r_tsel[2];
                rec.table_id = r_tsel[1:0];
                rec.entry_index = r_cnt;
                rec.value = {8'h00, i_data_byte};
                if ({4'h0, r_cnt} + 12'd1 >= r_sum) begin
                    if (r_rem > 0) n_phase = PH_DHT_INFO;
                    else if (r_rem != 0) err = ST_DHT_LEN;
                    else n_phase = PH_MK0;
                end else n_cnt = r_cnt + 8'd1;
            end
            PH_SOF_LL: begin
                n_flen = word;
                n_phase = PH_SOF_PREC;
            end
            PH_SOF_PREC: if (i_data_byte != 8'd8) err = ST_PREC; else n_phase = PH_SOF_HH;
            PH_SOF_HL: begin
                n_height = word;
                n_phase = PH_SOF_WH;
            end
            PH_SOF_WL: begin
                if (r_height == 16'd0 || word == 16'd0) err = ST_ZERO_DIM;
                else begin
                    have = 1'b1;
                    rec.rec_kind = K_FRAME;
                    rec.value = r_height;
                    rec.value2 = word;
                    n_phase = PH_SOF_NC;
                end
            end
            PH_SOF_NC: begin
                if (i_data_byte != 8'd1 && i_data_byte != 8'd3) err = ST_NCOMP;
                else begin
                    n_ncomp = i_data_byte[1:0];
                    n_cnt = '0;
                    n_phase = PH_SOF_CID;
                end
            end
            PH_SOF_CID: begin
                if (i_data_byte == 8'd0) n_zb = 1'b1;
                if (i_data_byte == 8'd0 || r_zb) cid = i_data_byte + 8'd1;
                if (cid == 8'd4 || cid == 8'd5) err = ST_YIQ;
                else if (cid == 8'd0 || cid > 8'd3) err = ST_BAD_CID;
                else if (r_used[cid[1:0] - 2'd1]) err = ST_DUP_COMP;
                else begin
                    n_used[cid[1:0] - 2'd1] = 1'b1;
                    n_tsel = {1'b0, cid[1:0] - 2'd1};
                    n_phase = PH_SOF_SAMP;
                end
            end
            PH_SOF_QT: begin
                if (i_data_byte >= 8'(TableIds)) err = ST_COMP_QT;
                else begin
                    have = 1'b1;
                    rec.rec_kind = K_COMP;
                    rec.entry_index = {5'd0, r_tsel};
                    rec.value = {8'h00, r_hi};
                    rec.value2 = {8'h00, i_data_byte};
                    n_cnt = r_cnt + 8'd1;
                    if (r_cnt + 8'd1 >= {6'd0, r_ncomp}) begin
                        if (r_flen != 16'd8 + 16'd3 * {14'd0, r_ncomp}) err = ST_SOF_LEN;
                        else n_phase = PH_MK0;
                    end else n_phase = PH_SOF_CID;
                end
            end
            PH_DRI_LL: begin
                if (word != 16'd4) n_warn[1] = 1'b1;
                n_phase = PH_DRI_IH;
            end
            PH_DRI_IL: begin
                have = 1'b1;
                rec.rec_kind = K_RST;
                rec.value = word;
                n_phase = PH_MK0;
            end
            default: n_phase = PH_SOI0;
        endcase

        if (err != ST_OK) begin
            rec = '0;
            have = 1'b1;
            rec.done_res = 1'b1;
            rec.status = err;
            n_stop = 1'b1;
        end else if (i_last) begin
            have = 1'b1;
            rec.done_res = 1'b1;
            if (n_phase == PH_MK0) rec.status = ST_OK;
            else if (n_phase == PH_SOI0 || n_phase == PH_SOI1) rec.status = ST_NO_SOI;
            else rec.status = ST_TRUNC;
        end
        rec.dqt_warn = n_warn[0];
        rec.dri_warn = n_warn[1];
        if (r_stop) have = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && i_last)) begin
            r_phase <= PH_SOI0; r_rem <= '0; r_cnt <= '0; r_tsel <= '0;
            r_wide <= 1'b0; r_hi <= '0; r_sum <= '0; r_flen <= '0;
            r_height <= '0; r_ncomp <= '0; r_zb <= 1'b0; r_used <= '0;
            r_stop <= 1'b0; r_warn <= '0;
        end else if (fire && !r_stop) begin
            r_phase <= n_phase; r_rem <= n_rem; r_cnt <= n_cnt; r_tsel <= n_tsel;
            r_wide <= n_wide; r_hi <= n_hi; r_sum <= n_sum; r_flen <= n_flen;
            r_height <= n_height; r_ncomp <= n_ncomp; r_zb <= n_zb;
            r_used <= n_used; r_stop <= n_stop; r_warn <= n_warn;
        end
    end

    assign o_res_valid = fire && have;
    assign o_res       = rec;

endmodule

FILE: rtl/core/jhmp_queue.sv
// Back part: small result queue feeding the output ports.
module jhmp_queue import jhmp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    localparam int AW = $clog2(QueueDepth);

    t_result         r_mem [QueueDepth];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            pop;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == (AW+1)'(QueueDepth);
    assign pop     = o_valid && !i_stall;
    assign o_res   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(QueueDepth - 1)) ? '0 : r_wp + 1'b1;
            if (pop) r_rp <= (r_rp == AW'(QueueDepth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_res;
    end

endmodule

FILE: rtl/core/jpeg_header_marker_parser.sv
// JPEG baseline header parser: takes one stream byte per transfer and walks SOI,
// APPn, DQT, DHT, SOF0 and DRI segments, giving at most one record per byte
// (quant entry in natural order, Huffman offset or symbol, frame size,
// component, restart interval) plus a done/status record on error or on the
// byte flagged last. It takes one byte per cycle while the result queue has
// room: the byte walker updates its phase on each accepted byte, and a
// two-entry result queue lets it keep taking bytes while the output side is
// stalled; input stalls only when that queue is full. After an error, bytes
// are swallowed without records until a byte flagged last.
module jpeg_header_marker_parser import jhmp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_rec_kind,
    output logic        o_table_class,
    output logic [1:0]  o_table_id,
    output logic [7:0]  o_entry_index,
    output logic [15:0] o_value,
    output logic [15:0] o_value2,
    output logic        o_done_res,
    output logic [4:0]  o_status,
    output logic        o_dqt_size_warning,
    output logic        o_dri_length_warning
);

    logic    push, full;
    t_result res, q_res;

    // front: walker classifies each byte
    jhmp_parse u_parse (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data_byte, .i_last,
        .o_res_valid(push), .o_res(res), .i_q_full(full)
    );

    // back: queued records drained to the output transfer
    jhmp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_res(res), .o_full(full),
        .o_valid, .i_stall, .o_res(q_res)
    );

    assign o_rec_kind           = q_res.rec_kind;
    assign o_table_class        = q_res.table_class;
    assign o_table_id           = q_res.table_id;
    assign o_entry_index        = q_res.entry_index;
    assign o_value              = q_res.value;
    assign o_value2             = q_res.value2;
    assign o_done_res           = q_res.done_res;
    assign o_status             = q_res.status;
    assign o_dqt_size_warning   = q_res.dqt_warn;
    assign o_dri_length_warning = q_res.dri_warn;

endmodule

FILE: rtl/core/jhmp_checker.sv
`include "jpeg_header_marker_parser_macros.svh"

module jhmp_checker import jhmp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_rec_kind,
    input logic        o_done_res,
    input logic [4:0]  o_status
);

    `JHMP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid,
        "result dropped while stalled")
    `JHMP_ASSERT_IMP(a_status_done, i_clk, i_rst_n, o_valid && !o_done_res,
        o_status == ST_OK, "status without done")
    `JHMP_ASSERT_IMP(a_err_none, i_clk, i_rst_n,
        o_valid && o_done_res && o_status != ST_OK && o_status != ST_NO_SOI && o_status != ST_TRUNC,
        o_rec_kind == K_NONE, "error record carries payload")
    `JHMP_ASSERT_IMP(a_kind_range, i_clk, i_rst_n, o_valid, o_rec_kind != 3'd7,
        "bad record kind")
    `JHMP_ASSERT_NXT(a_stall_full, i_clk, i_rst_n, !o_valid, !o_stall,
        "input stalled with empty output")

endmodule

bind jpeg_header_marker_parser jhmp_checker u_jhmp_checker (.*);

FILE: verif/tb_jpeg_header_marker_parser.sv
module tb_jpeg_header_marker_parser;
    import jhmp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_rec_kind;
    logic        o_table_class;
    logic [1:0]  o_table_id;
    logic [7:0]  o_entry_index;
    logic [15:0] o_value;
    logic [15:0] o_value2;
    logic        o_done_res;
    logic [4:0]  o_status;
    logic        o_dqt_size_warning;
    logic        o_dri_length_warning;

    jpeg_header_marker_parser dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_data_byte(i_data_byte), .i_last(i_last),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_rec_kind(o_rec_kind), .o_table_class(o_table_class),
        .o_table_id(o_table_id), .o_entry_index(o_entry_index),
        .o_value(o_value), .o_value2(o_value2),
        .o_done_res(o_done_res), .o_status(o_status),
        .o_dqt_size_warning(o_dqt_size_warning),
        .o_dri_length_warning(o_dri_length_warning)
    );

    // Parser phases, mirrored locally for the predictor.
    typedef enum int {
        P_SOI0, P_SOI1, P_MK0, P_MK1,
        P_APP_LH, P_APP_LL, P_APP_SKIP,
        P_DQT_LH, P_DQT_LL, P_DQT_INFO, P_DQT_ENT, P_DQT_LO,
        P_DHT_LH, P_DHT_LL, P_DHT_INFO, P_DHT_CNT, P_DHT_SYM,
        P_SOF_LH, P_SOF_LL, P_SOF_PREC, P_SOF_HH, P_SOF_HL, P_SOF_WH,
        P_SOF_WL, P_SOF_NC, P_SOF_CID, P_SOF_SAMP, P_SOF_QT,
        P_DRI_LH, P_DRI_LL, P_DRI_IH, P_DRI_IL
    } t_phase;

    // Stimulus row: byte, last flag, and an optional hand-typed expectation.
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hand;
        t_result    res;
    } t_row;

    // Parser state copy.
    t_phase      ph;
    int          seg_left;
    int unsigned cnt;
    logic [4:0]  tsel;
    bit          wide;
    logic [7:0]  hold;
    int unsigned sym_total;
    int unsigned frame_len;
    int unsigned height;
    int unsigned ncomp;
    bit          zero_ids;
    logic [2:0]  comp_seen;
    bit          halted;
    logic [1:0]  warn;

    t_result     record_q[$];
    t_row        rows[$];
    t_row        drive_q[$];
    int          n_errors;
    int          n_records;
    int          n_bytes;
    int          n_done;
    int          n_acc;
    bit          hold_off;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        n_errors++;
    endtask

    function automatic void parser_reset();
        ph = P_SOI0; seg_left = 0; cnt = 0; tsel = 0; wide = 0; hold = 0;
        sym_total = 0; frame_len = 0; height = 0; ncomp = 0; zero_ids = 0;
        comp_seen = 0; halted = 0; warn = 0;
    endfunction

    function automatic void dqt_tail();
        if (seg_left > 0) ph = P_DQT_INFO;
        else begin
            if (seg_left != 0) warn[0] = 1'b1;
            ph = P_MK0;
        end
    endfunction

    function automatic logic [4:0] dht_tail();
        if (seg_left > 0) begin
            ph = P_DHT_INFO;
            return ST_OK;
        end
        if (seg_left != 0) return ST_DHT_LEN;
        ph = P_MK0;
        return ST_OK;
    endfunction

    function automatic logic [5:0] natural_of(input int k);
        logic [5:0] zz[64] = '{
            0, 1, 8, 16, 9, 2, 3, 10, 17, 24, 32, 25, 18, 11, 4, 5,
            12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13, 6, 7, 14, 21, 28,
            35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
            58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63};
        return zz[k & 63];
    endfunction

    // Advance the parser copy by one byte; returns 1 with the record if one is due.
    function automatic bit parse_byte(input logic [7:0] b, input logic lst,
                                      output t_result r);
        logic [4:0]  err;
        bit          have;
        int unsigned len;
        int unsigned id;
        err = ST_OK;
        have = 0;
        r = '0;
        if (halted) begin
            if (lst) parser_reset();
            return 0;
        end
        case (ph)
            P_SOI0: if (b == MK_PREFIX) ph = P_SOI1; else err = ST_NO_SOI;
            P_SOI1: if (b == MK_SOI) ph = P_MK0; else err = ST_NO_SOI;
            P_MK0:  if (b == MK_PREFIX) ph = P_MK1; else err = ST_EXP_MK;
            P_MK1: begin
                if (b >= 8'hE0 && b <= 8'hEF) ph = P_APP_LH;
                else if (b == MK_DQT) ph = P_DQT_LH;
                else if (b == MK_DRI) ph = P_DRI_LH;
                else if (b == MK_DHT) ph = P_DHT_LH;
                else if (b == MK_SOF0) begin
                    if (ncomp != 0) err = ST_DUP_SOF; else ph = P_SOF_LH;
                end else ph = P_MK0;
            end
            P_APP_LH: begin hold = b; ph = P_APP_LL; end
            P_APP_LL: begin
                len = {hold, b};
                seg_left = (len >= 2) ? int'(len) - 2 : 0;
                ph = (seg_left > 0) ? P_APP_SKIP : P_MK0;
            end
            P_APP_SKIP: begin
                seg_left--;
                if (seg_left <= 0) ph = P_MK0;
            end
            P_DQT_LH: begin hold = b; ph = P_DQT_LL; end
            P_DQT_LL: begin
                seg_left = int'({hold, b}) - 2;
                dqt_tail();
            end
            P_DQT_INFO: begin
                id = b[3:0];
                seg_left--;
                if (id >= TableIds) err = ST_DQT_ID;
                else begin
                    tsel = 5'(id);
                    wide = b[7:4] != 0;
                    seg_left -= wide ? 128 : 64;
                    cnt = 0;
                    ph = P_DQT_ENT;
                end
            end
            P_DQT_ENT, P_DQT_LO: begin
                if (ph == P_DQT_ENT && wide) begin
                    hold = b;
                    ph = P_DQT_LO;
                end else begin
                    have = 1;
                    r.rec_kind = K_QUANT;
                    r.table_id = tsel[1:0];
                    r.entry_index = natural_of(cnt);
                    r.value = (ph == P_DQT_LO) ? {hold, b} : {8'h00, b};
                    cnt++;
                    if (cnt >= 64) dqt_tail(); else ph = P_DQT_ENT;
                end
            end
            P_DHT_LH: begin hold = b; ph = P_DHT_LL; end
            P_DHT_LL: begin
                seg_left = int'({hold, b}) - 2;
                err = dht_tail();
            end
            P_DHT_INFO: begin
                id = b[3:0];
                if (id >= TableIds) err = ST_DHT_ID;
                else begin
                    tsel = {(b[7:4] != 0), id[3:0]};
                    sym_total = 0;
                    cnt = 0;
                    ph = P_DHT_CNT;
                end
            end
            P_DHT_CNT: begin
                sym_total += b;
                cnt++;
                have = 1;
                r.rec_kind = K_HOFF;
                r.table_class = tsel[4];
                r.table_id = tsel[1:0];
                r.entry_index = 8'(cnt);
                r.value = 16'(sym_total);
                if (cnt >= 16) begin
                    seg_left -= 17 + int'(sym_total);
                    if (sym_total > MaxSymbols) err = ST_SYMS;
                    else if (sym_total == 0) err = dht_tail();
                    else begin
                        cnt = 0;
                        ph = P_DHT_SYM;
                    end
                end
            end
            P_DHT_SYM: begin
                have = 1;
                r.rec_kind = K_HSYM;
                r.table_class = tsel[4];
                r.table_id = tsel[1:0];
                r.entry_index = cnt[7:0];
                r.value = b;
                if (cnt + 1 >= sym_total) err = dht_tail(); else cnt++;
            end
            P_SOF_LH: begin hold = b; ph = P_SOF_LL; end
            P_SOF_LL: begin frame_len = {hold, b}; ph = P_SOF_PREC; end
            P_SOF_PREC: if (b != 8) err = ST_PREC; else ph = P_SOF_HH;
            P_SOF_HH: begin hold = b; ph = P_SOF_HL; end
            P_SOF_HL: begin height = {hold, b}; ph = P_SOF_WH; end
            P_SOF_WH: begin hold = b; ph = P_SOF_WL; end
            P_SOF_WL: begin
                len = {hold, b};
                if (height == 0 || len == 0) err = ST_ZERO_DIM;
                else begin
                    have = 1;
                    r.rec_kind = K_FRAME;
                    r.value = 16'(height);
                    r.value2 = 16'(len);
                    ph = P_SOF_NC;
                end
            end
            P_SOF_NC: begin
                if (b != 1 && b != 3) err = ST_NCOMP;
                else begin
                    ncomp = b;
                    cnt = 0;
                    ph = P_SOF_CID;
                end
            end
            P_SOF_CID: begin
                id = b;
                if (id == 0) zero_ids = 1;
                if (zero_ids) id = (id + 1) & 8'hFF;
                if (id == 4 || id == 5) err = ST_YIQ;
                else if (id == 0 || id > 3) err = ST_BAD_CID;
                else if (comp_seen[id-1]) err = ST_DUP_COMP;
                else begin
                    comp_seen[id-1] = 1'b1;
                    tsel = 5'(id - 1);
                    ph = P_SOF_SAMP;
                end
            end
            P_SOF_SAMP: begin hold = b; ph = P_SOF_QT; end
            P_SOF_QT: begin
                if (b >= TableIds) err = ST_COMP_QT;
                else begin
                    have = 1;
                    r.rec_kind = K_COMP;
                    r.entry_index = tsel;
                    r.value = hold;
                    r.value2 = b;
                    cnt++;
                    if (cnt >= ncomp) begin
                        if (frame_len != 8 + 3 * ncomp) err = ST_SOF_LEN;
                        else ph = P_MK0;
                    end else ph = P_SOF_CID;
                end
            end
            P_DRI_LH: begin hold = b; ph = P_DRI_LL; end
            P_DRI_LL: begin
                if ({hold, b} != 16'd4) warn[1] = 1'b1;
                ph = P_DRI_IH;
            end
            P_DRI_IH: begin hold = b; ph = P_DRI_IL; end
            P_DRI_IL: begin
                have = 1;
                r.rec_kind = K_RST;
                r.value = {hold, b};
                ph = P_MK0;
            end
            default: ph = P_SOI0;
        endcase
        if (err != ST_OK) begin
            r = '0;
            have = 1;
            r.done_res = 1'b1;
            r.status = err;
            halted = 1;
        end else if (lst) begin
            have = 1;
            r.done_res = 1'b1;
            if (ph == P_MK0) r.status = ST_OK;
            else if (ph == P_SOI0 || ph == P_SOI1) r.status = ST_NO_SOI;
            else r.status = ST_TRUNC;
        end
        if (have) begin
            r.dqt_warn = warn[0];
            r.dri_warn = warn[1];
        end
        if (lst) parser_reset();
        return have;
    endfunction

    // Row builders.
    function automatic void put(input int b, input logic lst = 1'b0);
        t_row w;
        w.data = 8'(b); w.last = lst; w.hand = 0; w.res = '0;
        rows.push_back(w);
    endfunction

    function automatic void put_err(input logic [7:0] b, input logic [4:0] st);
        t_row w;
        w.data = b; w.last = 0; w.hand = 1; w.res = '0;
        w.res.done_res = 1'b1; w.res.status = st;
        rows.push_back(w);
    endfunction

    function automatic void put_len(input int n);
        put(n[15:8]); put(n[7:0]);
    endfunction

    function automatic void put_soi();
        put(MK_PREFIX); put(MK_SOI);
    endfunction

    function automatic void put_rnd(input int n);
        repeat (n) put($urandom_range(0, 255));
    endfunction

    // Well-formed random segments, occasionally corrupted.
    function automatic void put_segment();
        int k, nsym, nc, len;
        int cnts[16];
        case ($urandom_range(0, 5))
            0: begin
                len = $urandom_range(0, 6);
                put(MK_PREFIX); put(8'hE0 | $urandom_range(0, 15)); put_len(len);
                if (len > 2) put_rnd(len - 2);
            end
            1: begin
                k = $urandom_range(0, 1);
                len = 2 + 1 + (k ? 128 : 64);
                if ($urandom_range(0, 5) == 0) len += $urandom_range(0, 3) - 1;
                put(MK_PREFIX); put(MK_DQT); put_len(len);
                put((k ? 8'h10 : 8'h00) | ($urandom_range(0, 9) == 0 ?
                    $urandom_range(4, 15) : $urandom_range(0, 3)));
                put_rnd(k ? 128 : 64);
            end
            2: begin
                nsym = 0;
                for (int i = 0; i < 16; i++) begin
                    cnts[i] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
                    nsym += cnts[i];
                end
                if ($urandom_range(0, 15) == 0) begin
                    cnts[0] = 200; nsym += 200;
                end
                len = 2 + 17 + nsym;
                if ($urandom_range(0, 7) == 0) len += 1;
                put(MK_PREFIX); put(MK_DHT); put_len(len);
                put({3'b000, 1'($urandom_range(0, 1)), 2'b00,
                     2'($urandom_range(0, 3))});
                for (int i = 0; i < 16; i++) put(cnts[i]);
                if (nsym <= MaxSymbols) put_rnd(nsym);
            end
            3: begin
                nc = $urandom_range(0, 1) ? 3 : 1;
                put(MK_PREFIX); put(MK_SOF0);
                put_len($urandom_range(0, 7) == 0 ? 8 + 3 * nc + 1 : 8 + 3 * nc);
                put($urandom_range(0, 9) == 0 ? 12 : 8);
                put_len($urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 65535));
                put_len($urandom_range(1, 65535));
                put($urandom_range(0, 11) == 0 ? $urandom_range(0, 4) : nc);
                k = $urandom_range(0, 1);
                for (int i = 0; i < nc; i++) begin
                    put($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : i + 1 - k);
                    put($urandom_range(0, 255));
                    put($urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 3));
                end
            end
            4: begin
                put(MK_PREFIX); put(MK_DRI);
                put_len($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : 4);
                put_len($urandom_range(0, 65535));
            end
            default: begin
                put(MK_PREFIX); put($urandom_range(0, 255));
            end
        endcase
    endfunction

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Sender: bursts of transfers with random gaps; payload held while stalled.
    initial begin
        int burst, gap;
        t_row w;
        i_valid = 0; i_data_byte = 0; i_last = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        burst = 0;
        while (drive_q.size() > 0 || i_valid) begin
            if (i_valid && !o_stall) begin
                // transfer accepted at this edge
                void'(drive_q.pop_front());
                n_bytes++;
            end
            if (!(i_valid && o_stall)) begin
                if (burst == 0 && $urandom_range(0, 3) == 0) begin
                    gap = $urandom_range(1, 6);
                    burst = $urandom_range(1, 40);
                    i_valid <= 0;
                    repeat (gap - 1) @(posedge i_clk);
                end else if (drive_q.size() > 0) begin
                    w = drive_q[0];
                    i_valid <= 1; i_data_byte <= w.data; i_last <= w.last;
                    if (burst > 0) burst--;
                end else i_valid <= 0;
            end
            @(posedge i_clk);
        end
    end

    // Receiver stall pattern, plus one long hold-off to back the block up.
    initial begin
        int phase;
        i_stall = 0;
        wait (i_rst_n);
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_off) i_stall <= 1;
            else case ((phase / 64) % 3)
                0: i_stall <= 0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= (phase % 5 < 2);
            endcase
        end
    end

    initial begin
        hold_off = 0;
        wait (n_bytes > 200);
        @(posedge i_clk);
        hold_off = 1;
        repeat (80) @(posedge i_clk);
        hold_off = 0;
    end

    // Prediction at each accepted input; compare at each accepted output.
    always @(posedge i_clk) begin
        t_result r, e;
        if (i_rst_n && i_valid && !o_stall) begin
            if (parse_byte(i_data_byte, i_last, r)) begin
                if (n_acc < rows.size() && rows[n_acc].hand) r = rows[n_acc].res;
                record_q.push_back(r);
            end
            n_acc++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            n_records++;
            if (record_q.size() == 0) report("unexpected record", o_rec_kind, 0);
            else begin
                e = record_q.pop_front();
                if (o_done_res) n_done++;
                if (o_rec_kind != e.rec_kind) report("rec_kind", o_rec_kind, e.rec_kind);
                if (o_table_class != e.table_class)
                    report("table_class", o_table_class, e.table_class);
                if (o_table_id != e.table_id) report("table_id", o_table_id, e.table_id);
                if (o_entry_index != e.entry_index)
                    report("entry_index", o_entry_index, e.entry_index);
                if (o_value != e.value) report("value", o_value, e.value);
                if (o_value2 != e.value2) report("value2", o_value2, e.value2);
                if (o_done_res != e.done_res) report("done_res", o_done_res, e.done_res);
                if (o_status != e.status) report("status", o_status, e.status);
                if (o_dqt_size_warning != e.dqt_warn)
                    report("dqt_size_warning", o_dqt_size_warning, e.dqt_warn);
                if (o_dri_length_warning != e.dri_warn)
                    report("dri_length_warning", o_dri_length_warning, e.dri_warn);
            end
        end
    end

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        n_errors = 0; n_records = 0; n_bytes = 0; n_done = 0; n_acc = 0;
        parser_reset();
        i_rst_n = 0;

        // Directed: bad start, several error codes, warnings, extremes, truncation.
        put_err(8'h00, ST_NO_SOI); put(8'hFF, 1);
        put(MK_PREFIX); put_err(8'h00, ST_NO_SOI); put(8'h12, 1);
        put_soi(); put_err(8'h7F, ST_EXP_MK); put(8'h00, 1);
        put_soi(); put(MK_PREFIX); put(8'hFF); put(MK_PREFIX); put(8'h01);
        put(MK_PREFIX); put(8'hEF); put_len(1);
        put(MK_PREFIX); put(MK_DQT); put_len(67); put_err(8'h0F, ST_DQT_ID);
        put(8'h00, 1);
        put_soi(); put(MK_PREFIX); put(MK_DQT); put_len(100); put(8'hF3);
        for (int i = 0; i < 128; i++) put(i[0] ? 8'hFF : 8'h00);
        put(MK_PREFIX); put(MK_DRI); put_len(5); put(8'hFF); put(8'hFF, 1);
        put_soi(); put(MK_PREFIX); put(MK_DHT); put_len(19); put_err(8'h14, ST_DHT_ID);
        put(8'h00, 1);
        put_soi(); put(MK_PREFIX); put(MK_DHT); put_len(30); put(8'h11);
        for (int i = 0; i < 16; i++) put(i == 15 ? 8'd163 : 8'd0);
        put(8'h00, 1);
        put_soi(); put(MK_PREFIX); put(MK_DHT); put_len(19); put(8'h00);
        for (int i = 0; i < 16; i++) put(8'd0);
        put(MK_PREFIX); put(MK_SOF0); put_len(11); put(8); put_len(65535);
        put_len(65535); put(1); put(0); put(8'hFF); put(3);
        put(MK_PREFIX); put_err(MK_SOF0, ST_DUP_SOF); put(8'h00, 1);
        put_soi(); put(MK_PREFIX); put(MK_SOF0); put_len(17); put(8); put_len(1);
        put_len(1); put(3); put(1); put(0); put(0); put(2); put(0); put(0);
        put_err(8'd4, ST_YIQ); put(8'h00, 1);
        put_soi(); put(MK_PREFIX); put(MK_SOF0); put_len(11); put(8); put_len(2);
        put_len(2); put(1); put(8'd200); put(8'h00, 1);
        put_soi(); put(MK_PREFIX); put(MK_DRI); put_len(4); put(8'h12, 1);
        put(8'hFF); put(8'hD8, 1);
        put_soi(); put(MK_PREFIX); put(MK_DRI); put_len(4); put_len(0); put(8'hFF, 1);

        // Random streams: mostly well-formed, some noise and truncation.
        while (rows.size() < 500) begin
            put_soi();
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 15) == 0) put_rnd($urandom_range(1, 3));
                put_segment();
            end
            put($urandom_range(0, 1) ? MK_PREFIX : $urandom_range(0, 255), 1);
        end

        foreach (rows[i]) drive_q.push_back(rows[i]);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        wait (drive_q.size() == 0);
        repeat (2) @(posedge i_clk);
        wait (record_q.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("Covered %0d bytes, %0d records, %0d stream ends, incl. a long output hold-off.",
                 n_bytes, n_records, n_done);
        if (n_errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
